// ----- rtl/fhp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhp_pkg
// Shared types and constants of the frame header parser: header layout,
// status codes, register indexes and the structs passed between stages.
// ----------------------------------------------------------------------------
package fhp_pkg;

    localparam int HdrBytes = 24;
    localparam int PosW     = 5;

    // byte offsets of the header fields
    localparam int VersionOff = 4;
    localparam int TypeOff    = 6;
    localparam int FlagsOff   = 8;
    localparam int LengthOff  = 12;
    localparam int TagOff     = 16;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] CfgMagic   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgVersion = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgMaxLen  = 2'd2;

    localparam logic [31:0] MagicRst   = 32'h0000_0000;
    localparam logic [15:0] VersionRst = 16'h0001;
    localparam logic [31:0] MaxLenRst  = 32'h0400_0000;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TRUNCATED   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_TOO_LARGE   = 3'd4
    } t_status;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_step;

    typedef struct packed {
        logic done;
        logic trunc;
    } t_evt;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] msg_type;
        logic [31:0] flags;
        logic [31:0] length;
        logic [55:0] tag_low;
    } t_hdr_fields;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [31:0] max_len;
    } t_cfg;

endpackage

// ----- rtl/fhp_gather.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhp_gather
// Byte position counter and header field registers; flags the completing
// byte and an early last byte.
// ----------------------------------------------------------------------------
module fhp_gather (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fhp_pkg::t_step       i_step,
    output fhp_pkg::t_evt        o_evt,
    output fhp_pkg::t_hdr_fields o_fields
);
    import fhp_pkg::*;

    logic [PosW-1:0] r_pos;
    logic [PosW-1:0] n_pos;
    t_hdr_fields     r_fields;
    t_evt            w_evt;

    always_comb begin
        w_evt.done  = i_step.valid && (r_pos == PosW'(HdrBytes - 1));
        w_evt.trunc = i_step.valid && i_step.last && !w_evt.done;
        if (w_evt.done || w_evt.trunc) begin
            n_pos = '0;
        end else if (i_step.valid) begin
            n_pos = r_pos + PosW'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // every byte of a field is written before it is read, so no clearing
    // the final tag byte goes straight to the result stage
    always_ff @(posedge i_clk) begin
        if (i_step.valid && !w_evt.done) begin
            priority if (r_pos < PosW'(VersionOff)) begin
                r_fields.magic[{r_pos[1:0], 3'b000} +: 8] <= i_step.data;
            end else if (r_pos < PosW'(TypeOff)) begin
                r_fields.version[{r_pos[0], 3'b000} +: 8] <= i_step.data;
            end else if (r_pos < PosW'(FlagsOff)) begin
                r_fields.msg_type[{r_pos[0], 3'b000} +: 8] <= i_step.data;
            end else if (r_pos < PosW'(LengthOff)) begin
                r_fields.flags[{r_pos[1:0], 3'b000} +: 8] <= i_step.data;
            end else if (r_pos < PosW'(TagOff)) begin
                r_fields.length[{r_pos[1:0], 3'b000} +: 8] <= i_step.data;
            end else begin
                r_fields.tag_low[{r_pos[2:0], 3'b000} +: 8] <= i_step.data;
            end
        end
    end

    assign o_evt    = w_evt;
    assign o_fields = r_fields;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < PosW'(HdrBytes))
        else $error("byte position beyond header");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_evt.done || w_evt.trunc) |=> (r_pos == '0))
        else $error("position not restarted after result");

endmodule

// ----- rtl/fhp_result.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhp_result
// Header checks against the configured values and the output word register.
// ----------------------------------------------------------------------------
module fhp_result (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  fhp_pkg::t_evt        i_evt,
    input  fhp_pkg::t_hdr_fields i_fields,
    input  logic [7:0]           i_data,
    input  fhp_pkg::t_cfg        i_cfg,
    output logic                 o_valid,
    output fhp_pkg::t_status     o_status,
    output logic [15:0]          o_message_type,
    output logic [31:0]          o_header_flags,
    output logic [31:0]          o_payload_length,
    output logic [63:0]          o_request_tag
);
    import fhp_pkg::*;

    t_status     n_status;
    logic        r_valid;
    t_status     r_status;
    logic [15:0] r_type;
    logic [31:0] r_flags;
    logic [31:0] r_length;
    logic [63:0] r_tag;
    logic        w_ok;

    always_comb begin
        priority if (i_evt.trunc) begin
            n_status = ST_TRUNCATED;
        end else if (i_fields.magic != i_cfg.magic) begin
            n_status = ST_BAD_MAGIC;
        end else if (i_fields.version != i_cfg.version) begin
            n_status = ST_BAD_VERSION;
        end else if (i_fields.length > i_cfg.max_len) begin
            n_status = ST_TOO_LARGE;
        end else begin
            n_status = ST_OK;
        end
        w_ok = (n_status == ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_evt.done || i_evt.trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_status <= n_status;
            r_type   <= w_ok ? i_fields.msg_type : '0;
            r_flags  <= w_ok ? i_fields.flags : '0;
            r_length <= w_ok ? i_fields.length : '0;
            r_tag    <= w_ok ? {i_data, i_fields.tag_low} : '0;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_message_type   = r_type;
    assign o_header_flags   = r_flags;
    assign o_payload_length = r_length;
    assign o_request_tag    = r_tag;

    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status != ST_OK)) |->
        ((r_type == '0) && (r_flags == '0) && (r_length == '0) && (r_tag == '0)))
        else $error("fields not zero on failed header");

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_evt.done, i_evt.trunc}))
        else $error("complete and truncated at once");

endmodule

// ----- rtl/frame_header_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_header_parser_top
// Assembles a 24-byte little-endian frame header from a byte stream and emits
// one checked result word per header, or a truncated word on an early last.
//
//   channel   dir   handshake                 payload
//   input     in    i_in_valid / o_in_stall   i_data_byte, i_last_byte
//   output    out   o_out_valid / i_out_stall o_status, o_message_type,
//                                             o_header_flags, o_payload_length,
//                                             o_request_tag
//   config    in    i_cfg_we                  i_cfg_index, i_cfg_data
//
// one byte per cycle while the output is not stalled; a result word is valid once
// the completing or truncating byte has passed the input register and then the
// result register
// synchronous active-low reset clears the position counter and both valids
// and loads the register defaults
// a stall on the output holds the result register and, once the input
// register is full, stalls the input
// ----------------------------------------------------------------------------
module frame_header_parser_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_last_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output fhp_pkg::t_status             o_status,
    output logic [15:0]                  o_message_type,
    output logic [31:0]                  o_header_flags,
    output logic [31:0]                  o_payload_length,
    output logic [63:0]                  o_request_tag,
    input  logic                         i_cfg_we,
    input  logic [fhp_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [fhp_pkg::CfgDataW-1:0] i_cfg_data
);
    import fhp_pkg::*;

    t_step       r_in;
    t_step       w_step;
    t_cfg        r_cfg;
    t_evt        w_evt;
    t_hdr_fields w_fields;
    logic        w_adv;

    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_in.valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in.data <= i_data_byte;
            r_in.last <= i_last_byte;
        end
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in.valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic   <= MagicRst;
            r_cfg.version <= VersionRst;
            r_cfg.max_len <= MaxLenRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgMagic:   r_cfg.magic   <= i_cfg_data;
                CfgVersion: r_cfg.version <= i_cfg_data[15:0];
                CfgMaxLen:  r_cfg.max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_step       = r_in;
        w_step.valid = r_in.valid && w_adv;
    end

    fhp_gather u_gather (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .o_evt    (w_evt),
        .o_fields (w_fields)
    );

    fhp_result u_result (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_adv),
        .i_evt            (w_evt),
        .i_fields         (w_fields),
        .i_data           (r_in.data),
        .i_cfg            (r_cfg),
        .o_valid          (o_out_valid),
        .o_status         (o_status),
        .o_message_type   (o_message_type),
        .o_header_flags   (o_header_flags),
        .o_payload_length (o_payload_length),
        .o_request_tag    (o_request_tag)
    );

endmodule
